>>> rtl/core/cbf_safety_filter_top_defines.svh
// Assertion macros shared by the filter RTL.
`ifndef CBF_SAFETY_FILTER_TOP_DEFINES_SVH
`define CBF_SAFETY_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CBF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cbf assertion failed");

// Next-cycle implication, checked outside reset.
`define CBF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cbf assertion failed");

`endif

>>> rtl/core/cbf_pkg.sv
`default_nettype none
package cbf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int THR_SHIFT = 2 * FRAC_BITS - 32;
    localparam int THR_UP    = (THR_SHIFT > 0) ? THR_SHIFT : 0;
    localparam int THR_DN    = (THR_SHIFT < 0) ? -THR_SHIFT : 0;

    localparam int F_W   = 66;   // signed factor, 2*FRAC_BITS fraction bits
    localparam int LEN_W = 64;   // |grad|^2
    localparam int P_W   = 96;   // factor * |grad_i|
    localparam int Q_W   = 41;   // quotient bits kept

    localparam logic [Q_W-1:0] SAT_LIM = Q_W'(64'd1 << 40);

    localparam logic [30:0] GAIN_RESET = 31'(64'd1 << FRAC_BITS);
    localparam logic [31:0] THR_RESET  = 32'd4295;

    localparam int IDX_W = 8;
    localparam logic [IDX_W-1:0] REG_GAIN = 8'd0;
    localparam logic [IDX_W-1:0] REG_THR  = 8'd1;

    localparam int FRONT_LAT = 3;
    localparam int AXIS_LAT  = 3 + Q_W + 1;
    localparam int LAT       = FRONT_LAT + AXIS_LAT;

    typedef struct packed {
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [31:0] ref_z;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
        logic signed [31:0] drift_term;
        logic signed [31:0] barrier_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] cmd_x;
        logic signed [31:0] cmd_y;
        logic signed [31:0] cmd_z;
    } rsp_t;

    typedef struct packed {
        logic signed [F_W-1:0] f;
        logic [LEN_W-1:0]      len2;
        logic                  pass;
    } front_t;

endpackage
`default_nettype wire

>>> rtl/core/cbf_front.sv
`default_nettype none
module cbf_front (
    input  wire logic           clk,
    input  wire logic           advance,
    input  wire cbf_pkg::req_t  item,
    input  wire logic [30:0]    gain,
    input  wire logic [31:0]    thr,
    output cbf_pkg::front_t     fr,
    output cbf_pkg::req_t       item_out
);

    localparam int LEN_W = cbf_pkg::LEN_W;
    localparam int F_W   = cbf_pkg::F_W;

    logic signed [63:0] sq_reg [3];
    logic signed [63:0] gr_reg [3];
    logic signed [63:0] sq_next [3];
    logic signed [63:0] gr_next [3];
    logic signed [63:0] gb_reg, gb_next;
    logic signed [31:0] g [3];
    logic signed [31:0] r [3];
    cbf_pkg::req_t      item1_reg, item2_reg, item3_reg;

    logic [cbf_pkg::LEN_W-1:0]      len2_reg, len2_next;
    logic signed [cbf_pkg::F_W-1:0] f_reg, f_next;
    cbf_pkg::front_t                fr_reg, fr_next;
    logic [cbf_pkg::LEN_W-1:0]      thr_ext;

    // Form the products
    always_comb
    begin
        g[0] = item.grad_x;
        g[1] = item.grad_y;
        g[2] = item.grad_z;
        r[0] = item.ref_x;
        r[1] = item.ref_y;
        r[2] = item.ref_z;
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = g[i] * g[i];
            gr_next[i] = g[i] * r[i];
        end
        gb_next = $signed({1'b0, gain}) * item.barrier_value;
    end

    // Sum into |grad|^2 and factor
    always_comb
    begin
        len2_next = LEN_W'(sq_reg[0]) + LEN_W'(sq_reg[1]) + LEN_W'(sq_reg[2]);
        f_next = -(F_W'(item1_reg.drift_term) <<< cbf_pkg::FRAC_BITS) - F_W'(gb_reg)
                 - F_W'(gr_reg[0]) - F_W'(gr_reg[1]) - F_W'(gr_reg[2]);
    end

    // Decide pass-through
    always_comb
    begin
        thr_ext = ((LEN_W'(thr) << cbf_pkg::THR_UP)
                   + ((LEN_W'(1) << cbf_pkg::THR_DN) - LEN_W'(1))) >> cbf_pkg::THR_DN;
        fr_next.f    = f_reg;
        fr_next.len2 = len2_reg;
        fr_next.pass = (len2_reg < thr_ext) || (len2_reg == '0)
                       || f_reg[F_W-1] || (f_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_reg    <= sq_next;
            gr_reg    <= gr_next;
            gb_reg    <= gb_next;
            item1_reg <= item;
            len2_reg  <= len2_next;
            f_reg     <= f_next;
            item2_reg <= item1_reg;
            fr_reg    <= fr_next;
            item3_reg <= item2_reg;
        end
    end

    assign fr       = fr_reg;
    assign item_out = item3_reg;

endmodule
`default_nettype wire

>>> rtl/core/cbf_axis.sv
`default_nettype none
module cbf_axis (
    input  wire logic               clk,
    input  wire logic               advance,
    input  wire cbf_pkg::front_t    fr,
    input  wire logic signed [31:0] r,
    input  wire logic signed [31:0] g,
    output logic signed [31:0]      cmd
);

    localparam int LEN_W = cbf_pkg::LEN_W;
    localparam int Q_W   = cbf_pkg::Q_W;
    localparam int P_W   = cbf_pkg::P_W;

    typedef struct packed {
        logic [LEN_W-1:0]   len2;
        logic signed [31:0] r;
        logic               gneg;
        logic               byp;
        logic               ovf;
    } side_t;

    logic [31:0]      mag;
    logic [31:0]      f_lo;
    logic [32:0]      f_hi;
    logic [63:0]      pl_reg;
    logic [64:0]      ph_reg;
    side_t            s1_reg, s1_next, s2_reg, s3_next;
    logic [P_W-1:0]   p_reg;
    logic [P_W-Q_W-1:0] p_top;

    side_t            side_d [0:Q_W];
    logic [LEN_W-1:0] rem_d  [0:Q_W];
    logic [Q_W-1:0]   num_d  [0:Q_W];
    logic [Q_W-1:0]   q_d    [0:Q_W];

    logic signed [42:0] sum;
    logic signed [31:0] cmd_reg, cmd_next;

    // Split factor times magnitude
    always_comb
    begin
        mag          = g[31] ? 32'(-g) : 32'(g);
        f_lo         = fr.f[31:0];
        f_hi         = fr.f[64:32];
        s1_next.len2 = fr.len2;
        s1_next.r    = r;
        s1_next.gneg = g[31];
        s1_next.byp  = fr.pass || (g == '0);
        s1_next.ovf  = 1'b0;
    end

    // Check quotient range and seed the divider
    always_comb
    begin
        p_top        = p_reg[P_W-1:Q_W];
        s3_next      = s2_reg;
        s3_next.ovf  = LEN_W'(p_top) >= s2_reg.len2;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pl_reg    <= f_lo * mag;
            ph_reg    <= f_hi * mag;
            s1_reg    <= s1_next;
            p_reg     <= (P_W'(ph_reg) << 32) + P_W'(pl_reg);
            s2_reg    <= s1_reg;
            side_d[0] <= s3_next;
            rem_d[0]  <= LEN_W'(p_top);
            num_d[0]  <= p_reg[Q_W-1:0];
            q_d[0]    <= '0;
        end
    end

    // Restoring divider, one quotient bit per stage
    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        logic [LEN_W:0] trial;
        logic [LEN_W:0] diff;
        logic           geq;

        always_comb
        begin
            trial = {rem_d[j], num_d[j][Q_W-1]};
            diff  = trial - {1'b0, side_d[j].len2};
            geq   = trial >= {1'b0, side_d[j].len2};
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_d[j+1]  <= geq ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
                num_d[j+1]  <= num_d[j] << 1;
                q_d[j+1]    <= {q_d[j][Q_W-2:0], geq};
                side_d[j+1] <= side_d[j];
            end
        end
    end

    // Apply correction and saturate
    always_comb
    begin
        sum = side_d[Q_W].gneg ? (43'(side_d[Q_W].r) - 43'(q_d[Q_W]))
                               : (43'(side_d[Q_W].r) + 43'(q_d[Q_W]));
        priority if (side_d[Q_W].byp)
            cmd_next = side_d[Q_W].r;
        else if (side_d[Q_W].ovf || (q_d[Q_W] > cbf_pkg::SAT_LIM))
            cmd_next = side_d[Q_W].gneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (sum > 43'sd2147483647)
            cmd_next = 32'sh7FFF_FFFF;
        else if (sum < -43'sd2147483648)
            cmd_next = 32'sh8000_0000;
        else
            cmd_next = sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd = cmd_reg;

endmodule
`default_nettype wire

>>> rtl/core/cbf_safety_filter_top.sv
`default_nettype none
// Closed-form CBF safety filter: one 3-D solve per item, Q16.16 in and out. An item is taken
// every cycle unless a held result stalls the pipeline; each axis has a 41-stage restoring
// divider behind a 3-stage product/sum front end and 3 stages of scaling, followed by one
// saturating output register. While a result waits under rsp_stall the whole pipeline holds
// and req_stall is raised. Configuration is written at any time
// through cfg_valid/cfg_index/cfg_data (cfg_ready is always high) but takes clean effect
// only while the pipeline is empty.
`include "cbf_safety_filter_top_defines.svh"
module cbf_safety_filter_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire cbf_pkg::req_t               req_item,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output cbf_pkg::rsp_t                    rsp_item,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [cbf_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [31:0]                 cfg_data
);

    logic [30:0]             gain_reg;
    logic [31:0]             thr_reg;
    logic [cbf_pkg::LAT-1:0] vld_reg;
    logic                    advance;
    logic                    gain_wr;
    logic                    thr_wr;
    cbf_pkg::front_t         fr;
    cbf_pkg::req_t           item3;

    // Freeze everything while the result is held
    assign advance   = !(vld_reg[cbf_pkg::LAT-1] && rsp_stall);
    assign req_stall = !advance;
    assign rsp_valid = vld_reg[cbf_pkg::LAT-1];
    assign cfg_ready = 1'b1;

    // Decode register writes
    assign gain_wr = cfg_valid && cfg_ready && (cfg_index == cbf_pkg::REG_GAIN);
    assign thr_wr  = cfg_valid && cfg_ready && (cfg_index == cbf_pkg::REG_THR);

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= cbf_pkg::GAIN_RESET;
            thr_reg  <= cbf_pkg::THR_RESET;
        end
        else
        begin
            if (gain_wr)
                gain_reg <= cfg_data[30:0];
            if (thr_wr)
                thr_reg <= cfg_data;
        end
    end

    // Advance item valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[cbf_pkg::LAT-2:0], req_valid};
    end

    cbf_front u_front (
        .clk      (clk),
        .advance  (advance),
        .item     (req_item),
        .gain     (gain_reg),
        .thr      (thr_reg),
        .fr       (fr),
        .item_out (item3)
    );

    cbf_axis u_axis_x (
        .clk (clk), .advance (advance), .fr (fr),
        .r (item3.ref_x), .g (item3.grad_x), .cmd (rsp_item.cmd_x)
    );

    cbf_axis u_axis_y (
        .clk (clk), .advance (advance), .fr (fr),
        .r (item3.ref_y), .g (item3.grad_y), .cmd (rsp_item.cmd_y)
    );

    cbf_axis u_axis_z (
        .clk (clk), .advance (advance), .fr (fr),
        .r (item3.ref_z), .g (item3.grad_z), .cmd (rsp_item.cmd_z)
    );

    `CBF_ASSERT_NEXT(a_enter, clk, rst_n, req_valid && !req_stall, vld_reg[0])
    `CBF_ASSERT_NEXT(a_gain_wr, clk, rst_n, gain_wr, gain_reg == $past(cfg_data[30:0]))
    `CBF_ASSERT_NEXT(a_thr_wr, clk, rst_n, thr_wr, thr_reg == $past(cfg_data))
    `CBF_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

endmodule
`default_nettype wire
